// File: hw/rtl/fmp_pkg.sv
// shared types and constants for the first missing positive block
// no dependencies; used by first_missing_positive_top, fmp_checker and tb
`timescale 1ns / 1ps
`default_nettype none

package fmp_pkg;

  localparam int VALUE_W = 32;   // width of the value field
  localparam int MISS_W  = 11;   // width of the missing field
  localparam int WORD_W  = 32;   // bitmap bits held in one memory word
  localparam int BIT_W   = 5;    // log2 of WORD_W

  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [MISS_W-1:0] missing;
    logic              overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/first_missing_positive_top.sv
// first missing positive: each element is marked in the bitmap in the cycle after its
// transfer; one element per cycle while idle. end item: result registered in ST_FINISH
// after a one-word-per-cycle scan of the NW = ceil(MAX_N/32) words of the bitmap memory.
// no items are taken during the scan; the scan also clears each word it reads.
// reset: synchronous; a clearing pass over all NW words zeroes the bitmap before the
// first item is taken
`timescale 1ns / 1ps
`default_nettype none

module first_missing_positive_top #(
  parameter int MAX_N = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output      logic            item_ready,
  input  wire fmp_pkg::item_t  item,
  output      logic            result_valid,
  input  wire logic            result_ready,
  output      fmp_pkg::result_t result
);

  localparam int NW     = (MAX_N + fmp_pkg::WORD_W - 1) / fmp_pkg::WORD_W;
  localparam int ADDR_W = (NW > 1) ? $clog2(NW) : 1;
  localparam int POS_W  = ADDR_W + fmp_pkg::BIT_W;
  localparam int CNT_W  = $clog2(MAX_N + 1);
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int EXT_W  = (CMP_W > fmp_pkg::MISS_W) ? CMP_W : fmp_pkg::MISS_W;
  localparam int WW     = fmp_pkg::WORD_W;
  localparam int BW     = fmp_pkg::BIT_W;

  fmp_pkg::state_t state, state_next;

  // bitmap memory
  logic [WW-1:0]     mem [NW];
  logic [WW-1:0]     rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WW-1:0]     wr_data;

  // element stage, forwarding and counters
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic [BW-1:0]     s1_bit;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [WW-1:0]     fwd_data;
  logic [CNT_W-1:0]  element_count;
  logic              overflowed;

  // scan
  logic [ADDR_W-1:0] scan_addr;
  logic              scan_rd_valid;
  logic [ADDR_W-1:0] scan_rd_addr;
  logic              found;
  logic [POS_W-1:0]  gap_pos;

  logic              item_fire;
  logic              is_element;
  logic              in_range;
  logic              room;
  logic [POS_W-1:0]  in_idx;
  logic [ADDR_W-1:0] in_word;
  logic [WW-1:0]     merge_base;
  logic [BW-1:0]     zero_bit;
  logic              word_has_zero;
  logic [POS_W-1:0]  word_pos;
  logic              found_now;
  logic [POS_W-1:0]  gap_now;
  logic [EXT_W-1:0]  gap_ext;
  logic [EXT_W-1:0]  count_ext;
  logic [EXT_W-1:0]  missing_ext;
  logic              scan_last;

  assign item_fire  = item_valid && item_ready;
  assign is_element = (item.kind == fmp_pkg::KIND_ELEMENT);
  assign room       = (element_count < CNT_W'(MAX_N));
  assign in_range   = !item.value[fmp_pkg::VALUE_W-1] && (item.value != '0) &&
                      ($unsigned(item.value) <= fmp_pkg::VALUE_W'(MAX_N));
  assign in_idx     = item.value[POS_W-1:0] - POS_W'(1);
  assign in_word    = in_idx[POS_W-1:BW];
  assign scan_last  = (scan_addr == ADDR_W'(NW - 1));

  // a word written in the previous cycle was read stale by the current element
  assign merge_base = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rdata;

  // first clear bit of the word returned by the scan
  always_comb begin
    zero_bit      = '0;
    word_has_zero = ~&rdata;
    for (int b = WW - 1; b >= 0; b--) begin
      if (!rdata[b]) begin
        zero_bit = BW'(b);
      end
    end
  end

  assign word_pos  = {scan_rd_addr, zero_bit};
  assign found_now = found || (scan_rd_valid && word_has_zero);
  assign gap_now   = found ? gap_pos : word_pos;
  assign gap_ext   = EXT_W'(gap_now);
  assign count_ext = EXT_W'(element_count);
  assign missing_ext = (found_now && (gap_ext < count_ext)) ? gap_ext + EXT_W'(1)
                                                            : count_ext + EXT_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fmp_pkg::ST_CLEAR: begin
        if (scan_last) state_next = fmp_pkg::ST_IDLE;
      end
      fmp_pkg::ST_IDLE: begin
        if (item_fire && !is_element) state_next = fmp_pkg::ST_SCAN;
      end
      fmp_pkg::ST_SCAN: begin
        if (scan_last) state_next = fmp_pkg::ST_FINISH;
      end
      fmp_pkg::ST_FINISH: begin
        state_next = fmp_pkg::ST_IDLE;
      end
      default: begin
        state_next = fmp_pkg::ST_CLEAR;
      end
    endcase
  end

  // handshake and memory port control
  always_comb begin
    item_ready = 1'b0;
    rd_addr    = scan_addr;
    wr_en      = s1_valid;
    wr_addr    = s1_addr;
    wr_data    = merge_base | (WW'(1) << s1_bit);
    case (state)
      fmp_pkg::ST_IDLE: begin
        // an end item waits until the previous result has been taken
        item_ready = !(item.kind == fmp_pkg::KIND_END && result_valid);
        rd_addr    = in_word;
      end
      fmp_pkg::ST_CLEAR, fmp_pkg::ST_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = scan_addr;
        wr_data = '0;
      end
      fmp_pkg::ST_FINISH: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // read-before-write memory, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fmp_pkg::ST_CLEAR;
      scan_addr     <= '0;
      scan_rd_valid <= 1'b0;
      s1_valid      <= 1'b0;
      fwd_valid     <= 1'b0;
      element_count <= '0;
      overflowed    <= 1'b0;
      found         <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      scan_rd_valid <= (state == fmp_pkg::ST_SCAN);
      s1_valid      <= item_fire && is_element && in_range && room;
      fwd_valid     <= s1_valid;

      if (state == fmp_pkg::ST_CLEAR || state == fmp_pkg::ST_SCAN) begin
        scan_addr <= scan_last ? '0 : scan_addr + ADDR_W'(1);
      end

      if (item_fire && is_element) begin
        if (room) begin
          element_count <= element_count + CNT_W'(1);
        end else begin
          overflowed <= 1'b1;
        end
      end

      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      if (state == fmp_pkg::ST_FINISH) begin
        result_valid  <= 1'b1;
        element_count <= '0;
        overflowed    <= 1'b0;
        found         <= 1'b0;
      end else if (scan_rd_valid && !found && word_has_zero) begin
        found <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_addr      <= in_word;
    s1_bit       <= in_idx[BW-1:0];
    fwd_addr     <= s1_addr;
    fwd_data     <= wr_data;
    // word address that goes with the read data of the next cycle
    scan_rd_addr <= scan_addr;
    if (scan_rd_valid && !found && word_has_zero) begin
      gap_pos <= word_pos;
    end
    if (state == fmp_pkg::ST_FINISH) begin
      result.missing  <= missing_ext[fmp_pkg::MISS_W-1:0];
      result.overflow <= overflowed;
    end
  end

  // element writes only happen while the scan is not running
  a_no_mark_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != fmp_pkg::ST_IDLE) |-> !s1_valid)
    else $error("element write outside idle");

  // an end transfer always starts a scan
  a_end_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (item_fire && !is_element) |=> (state == fmp_pkg::ST_SCAN))
    else $error("end transfer did not start scan");

  // a result only appears at the close of a scan
  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == fmp_pkg::ST_FINISH))
    else $error("result without scan");

  // the element count saturates at MAX_N
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(MAX_N))
    else $error("element count beyond limit");

endmodule

`default_nettype wire

// File: verif/fmp_checker.sv
// answer checker for first_missing_positive_top: follows both channels, works out
// each answer from the accepted elements and compares it on result transfers
// depends on fmp_pkg
`timescale 1ns / 1ps

module fmp_checker #(
  parameter int MAX_N = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  fmp_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  fmp_pkg::result_t result,
  output int               errors,
  output int               pending,
  output int               answers_seen
);

  logic [MAX_N-1:0] seen;
  int               set_size;
  logic             too_many;
  fmp_pkg::result_t owed[$];
  fmp_pkg::result_t want;

  function automatic logic [fmp_pkg::MISS_W-1:0] lowest_gap(
    input logic [MAX_N-1:0] marks, input int n);
    int i;
    i = 0;
    while (i < n && i < MAX_N && marks[i]) i++;
    return fmp_pkg::MISS_W'(i + 1);
  endfunction

  task automatic take_element(input logic signed [fmp_pkg::VALUE_W-1:0] v);
    // once the set is full further elements only raise the flag
    if (set_size >= MAX_N) begin
      too_many = 1'b1;
    end else begin
      set_size++;
      if (v >= 1 && v <= MAX_N) seen[v - 1] = 1'b1;
    end
  endtask

  task automatic forget_set();
    seen     = '0;
    set_size = 0;
    too_many = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      forget_set();
      owed.delete();
    end else begin
      // compare first: an answer leaving now belongs to an earlier set
      if (result_valid && result_ready) begin
        answers_seen++;
        if (owed.size() == 0) begin
          $error("result transfer with no answer owed: missing %0d overflow %0b",
                 result.missing, result.overflow);
          errors++;
        end else begin
          want = owed.pop_front();
          if (result.missing !== want.missing) begin
            $error("missing: expected %0d, got %0d", want.missing, result.missing);
            errors++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
            errors++;
          end
        end
      end
      if (item_valid && item_ready) begin
        if (item.kind == fmp_pkg::KIND_END) begin
          owed.push_back('{missing: lowest_gap(seen, set_size), overflow: too_many});
          forget_set();
        end else begin
          take_element(item.value);
        end
      end
    end
    pending = owed.size();
  end

endmodule

// File: verif/tb.sv
// testbench top for first_missing_positive_top: sends sets of elements with
// random gaps and result stalls; fmp_checker predicts and compares the answers
// depends on fmp_pkg, first_missing_positive_top and fmp_checker
`timescale 1ns / 1ps

module tb;

  localparam int MAX_N = 1024;

  logic             clk;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  fmp_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  fmp_pkg::result_t result;

  int errors, pending, answers_seen;
  int tx_idle, rx_idle, stall_left;
  int items_sent, sets_sent, full_sets;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  first_missing_positive_top #(.MAX_N(MAX_N)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  fmp_checker #(.MAX_N(MAX_N)) answer_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .errors       (errors),
    .pending      (pending),
    .answers_seen (answers_seen)
  );

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic push_item(input logic kind_bit,
                           input logic signed [fmp_pkg::VALUE_W-1:0] val);
    int gap_len;
    gap_len = 0;
    while (gap_len < 30 && $urandom_range(99) < tx_idle) gap_len++;
    if (gap_len > 0) begin
      item_valid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{kind: kind_bit, value: val};
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic close_set();
    // value is don't-care on end items, so it carries random bits
    push_item(fmp_pkg::KIND_END, $urandom);
    sets_sent++;
  endtask

  function automatic logic signed [fmp_pkg::VALUE_W-1:0] noise_value(input int len);
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return 0 - int'($urandom_range(5));
      2:       return MAX_N - 3 + $urandom_range(6);
      3:       return 1 + $urandom_range(len);
      default: return 32'h8000_0000 | $urandom;
    endcase
  endfunction

  // shuffled 1..len, some entries swapped for noise, a few noise extras
  task automatic send_perm(input int len, input int noise_pct, input int extras);
    logic signed [fmp_pkg::VALUE_W-1:0] vals[$];
    logic signed [fmp_pkg::VALUE_W-1:0] tmp;
    int j, k;
    for (j = 1; j <= len; j++) vals.push_back(j);
    for (j = len - 1; j > 0; j--) begin
      k       = $urandom_range(j);
      tmp     = vals[j];
      vals[j] = vals[k];
      vals[k] = tmp;
    end
    foreach (vals[idx]) begin
      if ($urandom_range(99) < noise_pct) vals[idx] = noise_value(len);
    end
    repeat (extras) vals.push_back(noise_value(len));
    foreach (vals[idx]) push_item(fmp_pkg::KIND_ELEMENT, vals[idx]);
    close_set();
    if (vals.size() > MAX_N) full_sets++;
  endtask

  task automatic random_set();
    int len, pct;
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12);
    pct = ($urandom_range(9) == 0) ? 100 : $urandom_range(2) * 15;
    send_perm(len, pct, $urandom_range(2));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // empty set
    close_set();
    push_item(fmp_pkg::KIND_ELEMENT, 1);
    close_set();
    // only non-positive and out-of-range values, nothing marked
    push_item(fmp_pkg::KIND_ELEMENT, 32'sh8000_0000);
    push_item(fmp_pkg::KIND_ELEMENT, 0);
    push_item(fmp_pkg::KIND_ELEMENT, 32'sh7fff_ffff);
    push_item(fmp_pkg::KIND_ELEMENT, -1);
    close_set();
    push_item(fmp_pkg::KIND_ELEMENT, MAX_N);
    push_item(fmp_pkg::KIND_ELEMENT, 1);
    close_set();
    // duplicates
    push_item(fmp_pkg::KIND_ELEMENT, 1);
    push_item(fmp_pkg::KIND_ELEMENT, 1);
    push_item(fmp_pkg::KIND_ELEMENT, 2);
    close_set();
    push_item(fmp_pkg::KIND_ELEMENT, 3);
    push_item(fmp_pkg::KIND_ELEMENT, 2);
    push_item(fmp_pkg::KIND_ELEMENT, 1);
    close_set();
    push_item(fmp_pkg::KIND_ELEMENT, MAX_N + 1);
    push_item(fmp_pkg::KIND_ELEMENT, 1);
    close_set();
    push_item(fmp_pkg::KIND_ELEMENT, 2);
    close_set();

    tx_idle = 18;
    rx_idle = 75;
    while (items_sent < 120) random_set();
    wait_drained();

    tx_idle = 75;
    rx_idle = 18;
    // long receiver hold-off while short sets keep coming, so the input backs up
    stall_left = 400;
    repeat (20) send_perm($urandom_range(3), 0, 0);
    wait_drained();
    while (items_sent < 240) random_set();
    wait_drained();

    tx_idle = 0;
    rx_idle = 0;
    // every value 1..MAX_N present plus two past capacity
    send_perm(MAX_N, 0, 2);
    while (items_sent < 1300) random_set();
    wait_drained();

    $display("%0d items in %0d sets (%0d past capacity), %0d answers checked",
             items_sent, sets_sent, full_sets, answers_seen);
    $display("three idling mixes, one long receiver hold-off, drained pauses between phases");
    if (errors == 0 && pending == 0) begin
      $display("first_missing_positive_top regression: pass");
    end else begin
      $display("first_missing_positive_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("first_missing_positive_top regression: fail");
    $finish;
  end

endmodule
